// File: sv/vptw_pkg.sv
// shared types and constants for the vertex projection block
`default_nettype none
package vptw_pkg;
   localparam int FracBits = 16;

   typedef enum logic [1:0] {
      ACT_LOAD_MODEL = 2'd0,
      ACT_LOAD_PROJ  = 2'd1,
      ACT_PROJECT    = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] window_x;
      logic signed [31:0] window_y;
      logic signed [31:0] window_depth;
      logic               w_was_zero;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MODEL,
      ST_PROJ,
      ST_DIV,
      ST_SCALE,
      ST_VIEW,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      hi = 72'sd2147483647;
      lo = -72'sd2147483648;
      if (v > hi) sat32 = 32'sh7fffffff;
      else if (v < lo) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
   endfunction
endpackage
`default_nettype wire

// File: sv/vptw_ram.sv
// generic single write, single registered read ram
`default_nettype none
module vptw_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/vptw_front.sv
// front end: classifies beats, loads matrices, queues points
`default_nettype none
module vptw_front import vptw_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         mat_we,
   output logic         mat_sel,
   output logic [3:0]   mat_addr,
   output logic [31:0]  mat_data,
   output logic         q_valid,
   input  wire logic    q_ready,
   output point_type    q_data
);
   // two entry point queue
   point_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic acc, is_pt, pop;

   // loads wait until queue drains so points see matrices in order
   assign req_ready = (req_data.action == ACT_PROJECT) ? (cnt_ff != 2'd2)
                                                       : (cnt_ff == 2'd0 && q_ready);
   assign acc   = req_valid && req_ready;
   assign is_pt = acc && req_data.action == ACT_PROJECT;
   assign pop   = q_valid && q_ready;
   assign mat_we   = acc && (req_data.action == ACT_LOAD_MODEL ||
                             req_data.action == ACT_LOAD_PROJ);
   assign mat_sel  = req_data.action == ACT_LOAD_PROJ;
   assign mat_addr = req_data.element_index;
   assign mat_data = req_data.element_value;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_data   = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, is_pt} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ is_pt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (is_pt) q_ff[wr_ff] <= '{x: req_data.point_x, y: req_data.point_y,
                                   z: req_data.point_z};
   end
endmodule
`default_nettype wire

// File: sv/vptw_back.sv
// back end: matrix transforms, reciprocal, viewport map
`default_nettype none
module vptw_back import vptw_pkg::*; #(
   parameter int FRAC_BITS = FracBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        mat_we,
   input  wire logic        mat_sel,
   input  wire logic [3:0]  mat_addr,
   input  wire logic [31:0] mat_data,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire point_type   q_data,
   input  wire logic signed [14:0] org_x,
   input  wire logic signed [14:0] org_y,
   input  wire logic [14:0] vw,
   input  wire logic [14:0] vh,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data
);
   localparam int DivBits = 2*FRAC_BITS + 1;
   localparam logic signed [71:0] One = 72'sd1 <<< FRAC_BITS;

   state_type st_ff, st_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  dcnt_ff;
   logic signed [31:0] vin_ff [4];
   logic signed [31:0] vout_ff [4];
   logic signed [71:0] acc_ff;
   logic [15:0] mv_ff;       // valid bits over ram (clear = identity)
   logic [15:0] pv_ff;
   logic [31:0] mrd, prd;
   logic [3:0]  rd_addr;
   logic [1:0]  row, col;
   logic [3:0]  ca;
   logic signed [31:0] elem;
   logic signed [71:0] prod, term;
   logic signed [31:0] sat_acc;
   // restoring divider
   logic [63:0] rem_ff;
   logic [DivBits-1:0] quo_ff;
   logic [63:0] quo_wide;
   logic [31:0] dvs_ff;
   logic        dneg_ff;
   logic [64:0] rtry;
   logic signed [31:0] recip;
   logic        wz_ff;
   logic [1:0]  sc_ff;
   logic signed [71:0] vmap;
   logic signed [71:0] depth;

   vptw_ram #(.Width(32), .Depth(16)) u_mram (
      .clock, .wr_en(mat_we && !mat_sel), .wr_addr(mat_addr), .wr_data(mat_data),
      .rd_addr, .rd_data(mrd));
   vptw_ram #(.Width(32), .Depth(16)) u_pram (
      .clock, .wr_en(mat_we && mat_sel), .wr_addr(mat_addr), .wr_data(mat_data),
      .rd_addr, .rd_data(prd));

   // cnt counts row*4+col, the ram is read at col*4+row for accumulation
   assign row = cnt_in[3:2];
   assign col = cnt_in[1:0];
   assign rd_addr = {col, row};

   assign ca = {cnt_ff[1:0], cnt_ff[3:2]};
   always_comb begin
      if (st_ff == ST_MODEL)
         elem = mv_ff[ca] ? mrd : ((ca[3:2] == ca[1:0]) ? One[31:0] : 32'sd0);
      else
         elem = pv_ff[ca] ? prd : ((ca[3:2] == ca[1:0]) ? One[31:0] : 32'sd0);
      prod = 72'(elem) * 72'(vin_ff[cnt_ff[1:0]]);
      term = prod >>> FRAC_BITS;
      sat_acc = sat32(acc_ff + term);
   end

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) begin st_in = ST_MODEL; cnt_in = '0; end
         ST_MODEL, ST_PROJ: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) st_in = (st_ff == ST_MODEL) ? ST_PROJ : ST_DIV;
         end
         ST_DIV: if (wz_ff || dcnt_ff == 6'(DivBits - 1)) st_in = ST_SCALE;
         ST_SCALE: if (sc_ff == 2'd2) st_in = ST_VIEW;
         ST_VIEW: st_in = ST_OUT;
         ST_OUT: if (rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_ready   = st_ff == ST_IDLE;
      rsp_valid = st_ff == ST_OUT;
      rtry      = {rem_ff, quo_ff[DivBits-1]} - {33'd0, dvs_ff};
   end

   assign vmap = 72'(org_x) <<< FRAC_BITS;
   assign depth = (72'(vout_ff[2]) + One) >>> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
         mv_ff  <= '0;
         pv_ff  <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         if (mat_we && !mat_sel) mv_ff[mat_addr] <= 1'b1;
         if (mat_we && mat_sel) pv_ff[mat_addr] <= 1'b1;
      end
      case (st_ff)
         ST_IDLE: begin
            vin_ff[0] <= q_data.x; vin_ff[1] <= q_data.y;
            vin_ff[2] <= q_data.z; vin_ff[3] <= One[31:0];
            acc_ff <= '0;
         end
         ST_MODEL, ST_PROJ: begin
            if (cnt_ff[1:0] == 2'd3) begin
               vout_ff[cnt_ff[3:2]] <= sat_acc;
               acc_ff <= '0;
               if (cnt_ff == 4'd15) begin
                  vin_ff[0] <= vout_ff[0]; vin_ff[1] <= vout_ff[1];
                  vin_ff[2] <= vout_ff[2]; vin_ff[3] <= sat_acc;
                  if (st_ff == ST_PROJ) begin
                     wz_ff   <= sat_acc == 32'sd0;
                     dneg_ff <= sat_acc[31];
                     dvs_ff  <= sat_acc[31] ? 32'(-sat_acc) : sat_acc;
                     rem_ff  <= '0;
                     quo_ff  <= DivBits'(1) << (DivBits-1);
                     dcnt_ff <= '0;
                  end
               end
            end else acc_ff <= acc_ff + term;
         end
         ST_DIV: begin
            // shifts dividend 2^(2F) one bit a cycle into remainder
            dcnt_ff <= dcnt_ff + 6'd1;
            if (!rtry[64]) begin
               rem_ff <= rtry[63:0];
               quo_ff <= {quo_ff[DivBits-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[62:0], quo_ff[DivBits-1]};
               quo_ff <= {quo_ff[DivBits-2:0], 1'b0};
            end
            sc_ff <= '0;
         end
         ST_SCALE: begin
            if (!wz_ff)
               vout_ff[sc_ff] <= sat32((72'(vout_ff[sc_ff]) * 72'(recip)) >>> FRAC_BITS);
            sc_ff <= sc_ff + 2'd1;
         end
         ST_VIEW: begin
            rsp_data.window_x <= sat32(vmap + ((72'($signed({1'b0, vw})) *
                                 (72'(vout_ff[0]) + One)) >>> 1));
            rsp_data.window_y <= sat32((72'(org_y) <<< FRAC_BITS) +
                                 ((72'($signed({1'b0, vh})) *
                                 (72'(vout_ff[1]) + One)) >>> 1));
            rsp_data.window_depth <= sat32(depth);
            rsp_data.w_was_zero   <= wz_ff;
         end
         default: ;
      endcase
   end

   // signed reciprocal from the quotient magnitude, saturated per sign
   assign quo_wide = 64'(quo_ff);
   always_comb begin
      if (!dneg_ff)
         recip = (quo_wide > 64'h7fffffff) ? 32'sh7fffffff : quo_wide[31:0];
      else
         recip = (quo_wide > 64'h80000000) ? 32'sh80000000 : -quo_wide[31:0];
   end
endmodule
`default_nettype wire

// File: sv/vertex_project_to_window.sv
// top level of the vertex projection block
`default_nettype none
// Load beats write one model or projection element each. A point beat is
// queued, then runs a start step, the two 4x4 transforms on one shared
// multiplier, the bit-serial reciprocal divider (cut short when clip w is
// zero), the scale step for x, y and z, the viewport step and the result
// beat, which is held until taken. Load beats wait until queued points have
// been transformed.
module vertex_project_to_window import vptw_pkg::*; #(
   parameter int FRAC_BITS = FracBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);
   logic signed [14:0] org_x_ff, org_y_ff;
   logic [14:0] vw_ff, vh_ff;
   logic mat_we, mat_sel, q_valid, q_ready;
   logic [3:0] mat_addr;
   logic [31:0] mat_data;
   point_type q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0; org_y_ff <= '0; vw_ff <= '0; vh_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: org_x_ff <= csr_data;
            CSR_ORIGIN_Y: org_y_ff <= csr_data;
            CSR_WIDTH:    vw_ff    <= csr_data;
            CSR_HEIGHT:   vh_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   vptw_front u_front (.clock, .reset, .req_valid, .req_ready, .req_data,
      .mat_we, .mat_sel, .mat_addr, .mat_data, .q_valid, .q_ready, .q_data);

   vptw_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clock, .reset, .mat_we, .mat_sel,
      .mat_addr, .mat_data, .q_valid, .q_ready, .q_data, .org_x(org_x_ff),
      .org_y(org_y_ff), .vw(vw_ff), .vh(vh_ff), .rsp_valid, .rsp_ready,
      .rsp_data);

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      mat_we |-> !q_valid) else $error("matrix load while points pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");
endmodule
`default_nettype wire

// File: test/vertex_project_to_window_tb.sv
// self-checking testbench for the vertex projection block
`default_nettype none
module vertex_project_to_window_tb;
   import vptw_pkg::*;

   class window_scoreboard;
      logic signed [31:0] model_m[16];
      logic signed [31:0] proj_m[16];
      logic signed [14:0] org_x, org_y;
      logic [14:0] size_w, size_h;
      rsp_type pending[$];
      int errors;

      function new();
         errors = 0;
         for (int i = 0; i < 16; i++) begin
            model_m[i] = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
            proj_m[i] = model_m[i];
         end
         org_x = 0; org_y = 0; size_w = 0; size_h = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [14:0] v);
         case (idx)
            CSR_ORIGIN_X: org_x = v;
            CSR_ORIGIN_Y: org_y = v;
            CSR_WIDTH: size_w = v;
            default: size_h = v;
         endcase
      endfunction

      function longint floor_sh(longint x, int s);
         return x >>> s;
      endfunction

      function longint clamp32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void transform(logic signed [31:0] m[16], longint vin[4], output longint vout[4]);
         longint acc;
         for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++)
               acc += floor_sh(longint'(m[c*4+r]) * vin[c], FracBits);
            vout[r] = clamp32(acc);
         end
      endfunction

      function longint to_window(longint org, longint size, longint c);
         return clamp32(org * (64'sd1 << FracBits) + floor_sh(size * (c + (64'sd1 << FracBits)), 1));
      endfunction

      function void note_input(req_type d);
         longint obj[4], eye[4], clip[4], recip;
         rsp_type e;
         case (action_type'(d.action))
            ACT_LOAD_MODEL: model_m[d.element_index] = d.element_value;
            ACT_LOAD_PROJ: proj_m[d.element_index] = d.element_value;
            ACT_PROJECT: begin
               obj[0] = d.point_x; obj[1] = d.point_y; obj[2] = d.point_z;
               obj[3] = 64'sd1 << FracBits;
               transform(model_m, obj, eye);
               transform(proj_m, eye, clip);
               e.w_was_zero = (clip[3] == 0);
               if (clip[3] != 0) begin
                  recip = clamp32((64'sd1 << (2*FracBits)) / clip[3]);
                  for (int i = 0; i < 3; i++)
                     clip[i] = clamp32(floor_sh(clip[i] * recip, FracBits));
               end
               e.window_x = 32'(to_window(longint'(org_x), longint'(size_w), clip[0]));
               e.window_y = 32'(to_window(longint'(org_y), longint'(size_h), clip[1]));
               e.window_depth = 32'(clamp32(floor_sh(clip[2] + (64'sd1 << FracBits), 1)));
               pending.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.window_x !== e.window_x) begin
            $display("%0t: window_x exp %h got %h", $time, e.window_x, a.window_x); errors++;
         end
         if (a.window_y !== e.window_y) begin
            $display("%0t: window_y exp %h got %h", $time, e.window_y, a.window_y); errors++;
         end
         if (a.window_depth !== e.window_depth) begin
            $display("%0t: depth exp %h got %h", $time, e.window_depth, a.window_depth); errors++;
         end
         if (a.w_was_zero !== e.w_was_zero) begin
            $display("%0t: w_was_zero exp %b got %b", $time, e.w_was_zero, a.w_was_zero); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [14:0] csr_data = 0;
   int send_idle = 0, recv_stall = 0;
   bit hold_off = 0;
   int quiet_cycles = 0;
   window_scoreboard sb;

   vertex_project_to_window dut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("vertex_project_to_window_tb NOT OK");
            $finish;
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_off && !($urandom_range(99) < recv_stall);

   // valid stays up after the beat; the next call drops it for idle cycles or replaces the data, drain drops it
   task automatic send_beat(req_type d);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_data <= d;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [14:0] v);
      csr_we <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(2, 0) << 16;
         3: return $urandom;
         default: return $signed($urandom_range(8 << 16)) - (4 << 16);
      endcase
   endfunction

   function automatic req_type rand_item(bit matrix_heavy);
      req_type d;
      int r;
      d.element_index = 4'($urandom);
      d.element_value = rand_word();
      d.point_x = rand_word(); d.point_y = rand_word(); d.point_z = rand_word();
      r = $urandom_range(99);
      if (r < 2) d.action = ACT_NONE;
      else if (r < (matrix_heavy ? 25 : 10)) d.action = ACT_LOAD_MODEL;
      else if (r < (matrix_heavy ? 50 : 20)) d.action = ACT_LOAD_PROJ;
      else d.action = ACT_PROJECT;
      // keep projection w row sensible most of the time
      if (d.action == ACT_LOAD_PROJ && d.element_index[1:0] == 2'd3 && $urandom_range(3) != 0)
         d.element_value = $urandom_range(3) == 0 ? 32'sh0 : $signed($urandom_range(4 << 16)) - (2 << 16);
      return d;
   endfunction

   task automatic set_view(logic [14:0] ox, logic [14:0] oy, logic [14:0] w, logic [14:0] h);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      csr_we <= 0;
   endtask

   initial begin
      req_type d;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      set_view(15'd10, 15'd20, 15'd640, 15'd480);

      // directed: identity projection, extremes, undefined action, zero and tiny w, matrix loads
      d = '0; d.action = ACT_PROJECT;
      send_beat(d);
      d.point_x = 32'h7fffffff; d.point_y = 32'h80000000; d.point_z = 32'h00010000;
      send_beat(d);
      d.action = ACT_NONE; send_beat(d);
      d = '0; d.action = ACT_LOAD_PROJ; d.element_index = 4'd15; d.element_value = 0;
      send_beat(d);                         // zero w
      d.action = ACT_PROJECT; d.point_x = 32'h00008000; d.point_y = 32'hffff8000;
      send_beat(d);
      d = '0; d.action = ACT_LOAD_PROJ; d.element_index = 4'd15; d.element_value = 32'sh1;
      send_beat(d);                         // tiny w
      d.action = ACT_PROJECT; d.point_x = 32'h00004000; d.point_z = 32'hffff0000;
      send_beat(d);
      d = '0; d.action = ACT_LOAD_MODEL; d.element_index = 4'd12;
      d.element_value = 32'h7fffffff; send_beat(d);
      d.action = ACT_LOAD_PROJ; d.element_index = 4'd15; d.element_value = 32'h80000000;
      send_beat(d);
      d.action = ACT_PROJECT; d.point_x = 32'hffffffff; send_beat(d);
      drain();
      set_view(15'h4000, 15'h3fff, 15'h7fff, 15'd0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 83; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 83; end
            default: begin send_idle = 12; recv_stall = 12; end
         endcase
         if (phase == 4) begin
            fork
               begin
                  hold_off = 1;
                  repeat (2000) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int n = 0; n < 115; n++) send_beat(rand_item(n % 20 < 3));
         drain();
         case (phase)
            0: set_view(15'h7fff, 15'h4000, 15'd16384, 15'd16384);
            1: set_view(15'd0, 15'd0, 15'd1, 15'd2);
            2: set_view(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
            3: set_view(15'h3fff, 15'h4000, 15'd0, 15'd16384);
            default: set_view(15'd100, 15'd200, 15'd1920, 15'd1080);
         endcase
      end
      drain();
      if (sb.errors == 0) $display("vertex_project_to_window_tb OK");
      else $display("vertex_project_to_window_tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
